### sv/wsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the WebSocket frame deframer.
// Used by the channel interfaces and the top level; depends on nothing.
package wsd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 63;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned KEY_W  = 32;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Result kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_HEADER  = 2'd0;
  localparam kind_t KIND_PAYLOAD = 2'd1;
  localparam kind_t KIND_ERROR   = 2'd2;

  // Error codes
  typedef logic [1:0] err_t;
  localparam err_t ERR_OPCODE  = 2'd0;
  localparam err_t ERR_INFLATE = 2'd1;
  localparam err_t ERR_TOPBIT  = 2'd2;

  // Opcodes accepted on header byte one
  typedef logic [3:0] opcode_t;
  localparam opcode_t OP_CONT  = 4'h0;
  localparam opcode_t OP_TEXT  = 4'h1;
  localparam opcode_t OP_BIN   = 4'h2;
  localparam opcode_t OP_CLOSE = 4'h8;
  localparam opcode_t OP_PING  = 4'h9;
  localparam opcode_t OP_PONG  = 4'hA;

  // Seven-bit length escapes and the minimum 16-bit extended length
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [15:0] MIN_EXT16 = 16'd126;

endpackage : wsd_pkg
`default_nettype wire

### sv/wsd_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces: raw byte input and decoded result output.
// Depends on wsd_pkg for payload types.
interface wsd_byte_if
  import wsd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface : wsd_byte_if

interface wsd_result_if
  import wsd_pkg::*;
();
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic       fin;
  logic [2:0] rsv_bits;
  opcode_t    opcode;
  logic       masked;
  len_t       payload_length;
  byte_t      data_out;
  logic       last;
  err_t       error_code;

  modport source (output valid, output kind, output fin, output rsv_bits, output opcode,
                  output masked, output payload_length, output data_out, output last,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input fin, input rsv_bits, input opcode,
                  input masked, input payload_length, input data_out, input last,
                  input error_code, output ready);
endinterface : wsd_result_if
`default_nettype wire

### sv/websocket_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// WebSocket frame deframer top level: byte input register, header/payload
// parser and result register. Depends on wsd_pkg and wsd_chan_if.
//
//   channel | dir | handshake      | payload
//   in_ch   | in  | valid/ready    | byte_in[7:0]
//   out_ch  | out | valid/ready    | kind, fin, rsv_bits, opcode, masked,
//           |     |                | payload_length, data_out, last, error_code
//
// One byte per cycle unless out_ch stalls; a result is registered from its
// input byte, the parser sitting between the input and result registers.
// Reset returns the parser to the first header byte and clears any fault.
// A stall on out_ch holds the result register; the input register then
// fills and in_ch.ready drops until the result is taken.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  wsd_byte_if.sink     in_ch,
  wsd_result_if.source out_ch
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXT16,
    PH_EXT64,
    PH_MASK,
    PH_PAYLOAD,
    PH_FAULT
  } phase_t;

  // Input register
  logic  in_vld_r;
  byte_t in_byte_r;

  // Parser state
  phase_t           phase_r, phase_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  byte_t            first_r, first_nxt;
  logic             mask_r, mask_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  len_t             rem_r, rem_nxt;
  logic [1:0]       midx_r, midx_nxt;

  // Result register
  logic       out_vld_r;
  kind_t      kind_r, kind_nxt;
  logic       fin_r, fin_nxt;
  logic [2:0] rsv_r, rsv_nxt;
  opcode_t    op_r, op_nxt;
  logic       masked_r, masked_nxt;
  len_t       len_r, len_nxt;
  byte_t      data_r, data_nxt;
  logic       last_r, last_nxt;
  err_t       err_r, err_nxt;
  logic       emit;

  logic p_go;
  logic in_rdy;

  logic [ACC_W-1:0] acc_sh;
  opcode_t          b_op;
  logic             op_ok;
  byte_t            key_byte;
  len_t             rem_dec;

  assign p_go   = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_rdy = !in_vld_r || p_go;
  assign in_ch.ready = in_rdy;

  assign acc_sh  = {acc_r[ACC_W-BYTE_W-1:0], in_byte_r};
  assign b_op    = in_byte_r[3:0];
  assign op_ok   = (b_op == OP_CONT) || (b_op == OP_TEXT) || (b_op == OP_BIN) ||
                   (b_op == OP_CLOSE) || (b_op == OP_PING) || (b_op == OP_PONG);
  assign rem_dec = (rem_r != '0) ? rem_r - len_t'(1) : rem_r;

  always_comb begin
    case (midx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    logic       hdr;
    len_t       hdr_len;
    logic       hdr_mask;
    hdr       = 1'b0;
    hdr_len   = len_t'(acc_r);
    hdr_mask  = mask_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    mask_nxt  = mask_r;
    acc_nxt   = acc_r;
    key_nxt   = key_r;
    rem_nxt   = rem_r;
    midx_nxt  = midx_r;
    emit       = 1'b0;
    kind_nxt   = KIND_HEADER;
    fin_nxt    = 1'b0;
    rsv_nxt    = '0;
    op_nxt     = '0;
    masked_nxt = 1'b0;
    len_nxt    = '0;
    data_nxt   = '0;
    last_nxt   = 1'b0;
    err_nxt    = ERR_OPCODE;

    case (phase_r)
      PH_FIRST: begin
        first_nxt = in_byte_r;
        if (!op_ok) begin
          emit      = 1'b1;
          kind_nxt  = KIND_ERROR;
          err_nxt   = ERR_OPCODE;
          phase_nxt = PH_FAULT;
        end else begin
          phase_nxt = PH_SECOND;
        end
      end
      PH_SECOND: begin
        mask_nxt = in_byte_r[7];
        cnt_nxt  = '0;
        acc_nxt  = '0;
        if (in_byte_r[6:0] == LEN7_EXT16) begin
          phase_nxt = PH_EXT16;
        end else if (in_byte_r[6:0] == LEN7_EXT64) begin
          phase_nxt = PH_EXT64;
        end else begin
          acc_nxt = ACC_W'(in_byte_r[6:0]);
          if (in_byte_r[7]) begin
            key_nxt   = '0;
            phase_nxt = PH_MASK;
          end else begin
            hdr      = 1'b1;
            hdr_len  = len_t'(in_byte_r[6:0]);
            hdr_mask = 1'b0;
          end
        end
      end
      PH_EXT16, PH_EXT64: begin
        acc_nxt = acc_sh;
        cnt_nxt = cnt_r + 3'd1;
        if ((phase_r == PH_EXT16 && cnt_r == 3'd1) ||
            (phase_r == PH_EXT64 && cnt_r == 3'd7)) begin
          cnt_nxt = '0;
          if (phase_r == PH_EXT16 && acc_sh[15:0] < MIN_EXT16) begin
            emit      = 1'b1;
            kind_nxt  = KIND_ERROR;
            err_nxt   = ERR_INFLATE;
            phase_nxt = PH_FAULT;
          end else if (phase_r == PH_EXT64 && acc_sh[ACC_W-1:16] == '0) begin
            emit      = 1'b1;
            kind_nxt  = KIND_ERROR;
            err_nxt   = ERR_INFLATE;
            phase_nxt = PH_FAULT;
          end else if (phase_r == PH_EXT64 && acc_sh[ACC_W-1]) begin
            emit      = 1'b1;
            kind_nxt  = KIND_ERROR;
            err_nxt   = ERR_TOPBIT;
            phase_nxt = PH_FAULT;
          end else if (mask_r) begin
            key_nxt   = '0;
            phase_nxt = PH_MASK;
          end else begin
            hdr     = 1'b1;
            hdr_len = len_t'(acc_sh);
          end
        end
      end
      PH_MASK: begin
        key_nxt = {key_r[KEY_W-BYTE_W-1:0], in_byte_r};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          cnt_nxt = '0;
          hdr     = 1'b1;
          hdr_len = len_t'(acc_r);
        end
      end
      PH_PAYLOAD: begin
        emit     = 1'b1;
        kind_nxt = KIND_PAYLOAD;
        data_nxt = mask_r ? (in_byte_r ^ key_byte) : in_byte_r;
        midx_nxt = midx_r + 2'd1;
        rem_nxt  = rem_dec;
        if (rem_dec == '0) begin
          last_nxt  = 1'b1;
          phase_nxt = PH_FIRST;
        end
      end
      PH_FAULT: begin
        // drop every item until reset
      end
      default: begin
        phase_nxt = PH_FIRST;
      end
    endcase

    if (hdr) begin
      emit       = 1'b1;
      kind_nxt   = KIND_HEADER;
      fin_nxt    = first_r[7];
      rsv_nxt    = first_r[6:4];
      op_nxt     = first_r[3:0];
      masked_nxt = hdr_mask;
      len_nxt    = hdr_len;
      rem_nxt    = hdr_len;
      midx_nxt   = '0;
      if (hdr_len == '0) begin
        last_nxt  = 1'b1;
        phase_nxt = PH_FIRST;
      end else begin
        phase_nxt = PH_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_FIRST;
      cnt_r     <= '0;
      first_r   <= '0;
      mask_r    <= 1'b0;
      acc_r     <= '0;
      key_r     <= '0;
      rem_r     <= '0;
      midx_r    <= '0;
    end else begin
      if (in_ch.valid && in_rdy) begin
        in_vld_r <= 1'b1;
      end else if (p_go) begin
        in_vld_r <= 1'b0;
      end
      if (p_go) begin
        out_vld_r <= emit;
        phase_r   <= phase_nxt;
        cnt_r     <= cnt_nxt;
        first_r   <= first_nxt;
        mask_r    <= mask_nxt;
        acc_r     <= acc_nxt;
        key_r     <= key_nxt;
        rem_r     <= rem_nxt;
        midx_r    <= midx_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_rdy) begin
      in_byte_r <= in_ch.byte_in;
    end
    if (p_go && emit) begin
      kind_r   <= kind_nxt;
      fin_r    <= fin_nxt;
      rsv_r    <= rsv_nxt;
      op_r     <= op_nxt;
      masked_r <= masked_nxt;
      len_r    <= len_nxt;
      data_r   <= data_nxt;
      last_r   <= last_nxt;
      err_r    <= err_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.fin            = fin_r;
  assign out_ch.rsv_bits       = rsv_r;
  assign out_ch.opcode         = op_r;
  assign out_ch.masked         = masked_r;
  assign out_ch.payload_length = len_r;
  assign out_ch.data_out       = data_r;
  assign out_ch.last           = last_r;
  assign out_ch.error_code     = err_r;

endmodule : websocket_frame_deframer
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for websocket_frame_deframer: drives whole frames byte by byte
// and compares every result against an in-bench frame parser.
// Depends on wsd_pkg and the wsd_byte_if / wsd_result_if channel interfaces.
import wsd_pkg::*;

typedef struct packed {
  kind_t      kind;
  logic       fin;
  logic [2:0] rsv_bits;
  opcode_t    opcode;
  logic       masked;
  len_t       payload_length;
  byte_t      data_out;
  logic       last;
  err_t       error_code;
} deframe_result_t;

typedef enum logic [2:0] {
  AWAIT_B0, AWAIT_B1, IN_EXT16, IN_EXT64, IN_KEY, IN_PAYLOAD
} parse_phase_e;

class FrameScoreboard;
  deframe_result_t expected_q[$];
  int unsigned     failures;

  parse_phase_e phase;
  logic [3:0]   hdr_cnt;
  byte_t        first_b;
  logic         has_mask;
  logic [63:0]  len_acc;
  logic [31:0]  key;
  len_t         remaining;
  logic [1:0]   key_idx;
  logic         faulted;

  function new();
    failures  = 0;
    phase     = AWAIT_B0;
    hdr_cnt   = '0;
    first_b   = '0;
    has_mask  = 1'b0;
    len_acc   = '0;
    key       = '0;
    remaining = '0;
    key_idx   = '0;
    faulted   = 1'b0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void raise_fault(err_t code);
    deframe_result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    faulted = 1'b1;
    expected_q.push_back(r);
  endfunction

  function void open_payload();
    deframe_result_t r;
    r = '0;
    r.kind = KIND_HEADER;
    r.fin = first_b[7];
    r.rsv_bits = first_b[6:4];
    r.opcode = first_b[3:0];
    r.masked = has_mask;
    r.payload_length = len_acc[62:0];
    remaining = len_acc[62:0];
    key_idx = '0;
    if (len_acc[62:0] == '0) begin
      r.last = 1'b1;
      phase = AWAIT_B0;
    end else begin
      phase = IN_PAYLOAD;
    end
    expected_q.push_back(r);
  endfunction

  // Length known: collect the key next, or open the payload right away.
  function void length_known();
    hdr_cnt = '0;
    if (has_mask) begin
      key = '0;
      phase = IN_KEY;
    end else begin
      open_payload();
    end
  endfunction

  function void note_byte(byte_t b);
    deframe_result_t r;
    logic [3:0] op;
    byte_t d;
    r = '0;
    if (faulted) return;
    case (phase)
      AWAIT_B0: begin
        first_b = b;
        op = b[3:0];
        if (op == OP_CONT || op == OP_TEXT || op == OP_BIN || op == OP_CLOSE ||
            op == OP_PING || op == OP_PONG)
          phase = AWAIT_B1;
        else
          raise_fault(ERR_OPCODE);
      end
      AWAIT_B1: begin
        has_mask = b[7];
        len_acc = '0;
        hdr_cnt = '0;
        if (b[6:0] == LEN7_EXT16) begin
          phase = IN_EXT16;
        end else if (b[6:0] == LEN7_EXT64) begin
          phase = IN_EXT64;
        end else begin
          len_acc = {57'd0, b[6:0]};
          length_known();
        end
      end
      IN_EXT16: begin
        len_acc = {len_acc[55:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt == 4'd2) begin
          if (len_acc < {48'd0, MIN_EXT16}) raise_fault(ERR_INFLATE);
          else length_known();
        end
      end
      IN_EXT64: begin
        len_acc = {len_acc[55:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt == 4'd8) begin
          if (len_acc < 64'd65536) raise_fault(ERR_INFLATE);
          else if (len_acc[63]) raise_fault(ERR_TOPBIT);
          else length_known();
        end
      end
      IN_KEY: begin
        key = {key[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt == 4'd4) begin
          hdr_cnt = '0;
          open_payload();
        end
      end
      IN_PAYLOAD: begin
        d = has_mask ? (b ^ key[8*(3-int'(key_idx)) +: 8]) : b;
        r.kind = KIND_PAYLOAD;
        r.data_out = d;
        key_idx = key_idx + 2'd1;
        if (remaining != '0) remaining = remaining - 1'b1;
        if (remaining == '0) begin
          r.last = 1'b1;
          phase = AWAIT_B0;
        end
        expected_q.push_back(r);
      end
      default: phase = AWAIT_B0;
    endcase
  endfunction

  function string show(deframe_result_t r);
    return $sformatf("kind=%0d fin=%0d rsv=%0d op=%0h mask=%0d len=%0d data=%02h last=%0d err=%0d",
                     r.kind, r.fin, r.rsv_bits, r.opcode, r.masked, r.payload_length,
                     r.data_out, r.last, r.error_code);
  endfunction

  function void check_result(deframe_result_t got);
    deframe_result_t exp;
    if (expected_q.size() == 0) begin
      failures++;
      if (failures <= 10) $display("unexpected result: %s", show(got));
      return;
    end
    exp = expected_q.pop_front();
    if (got.kind !== exp.kind || got.fin !== exp.fin || got.rsv_bits !== exp.rsv_bits ||
        got.opcode !== exp.opcode || got.masked !== exp.masked ||
        got.payload_length !== exp.payload_length || got.data_out !== exp.data_out ||
        got.last !== exp.last || got.error_code !== exp.error_code) begin
      failures++;
      if (failures <= 10) begin
        $display("result mismatch at %0t", $realtime);
        $display("  expected %s", show(exp));
        $display("  actual   %s", show(got));
      end
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned CYCLE_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned STALL_LEN    = 400;

  typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_code_e;

  logic clk;
  logic rst_n;

  wsd_byte_if   in_if ();
  wsd_result_if out_if ();

  websocket_frame_deframer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  FrameScoreboard sb;
  int unsigned    bytes_sent;
  int unsigned    cycle_count;
  bit             no_idle;
  int unsigned    stall_asked;
  int unsigned    stall_served;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random back-pressure plus long hold-offs on request.
  initial begin
    int unsigned hold;
    hold = 0;
    stall_served = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_served != stall_asked) begin
        stall_served = stall_asked;
        hold = STALL_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= 23);
      end
    end
  end

  always @(posedge clk) begin
    deframe_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind = out_if.kind;
      got.fin = out_if.fin;
      got.rsv_bits = out_if.rsv_bits;
      got.opcode = out_if.opcode;
      got.masked = out_if.masked;
      got.payload_length = out_if.payload_length;
      got.data_out = out_if.data_out;
      got.last = out_if.last;
      got.error_code = out_if.error_code;
      sb.check_result(got);
    end
  end

  task automatic push_byte(input byte_t b);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.byte_in <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                             input logic mask, input len_code_e enc,
                             input logic [63:0] len_field, input logic [31:0] mask_key);
    int i;
    push_byte({fin, rsv, op});
    case (enc)
      LEN_SHORT: begin
        push_byte({mask, len_field[6:0]});
      end
      LEN_EXT16: begin
        push_byte({mask, LEN7_EXT16});
        for (i = 1; i >= 0; i--) push_byte(len_field[8*i +: 8]);
      end
      default: begin
        push_byte({mask, LEN7_EXT64});
        for (i = 7; i >= 0; i--) push_byte(len_field[8*i +: 8]);
      end
    endcase
    if (mask)
      for (i = 3; i >= 0; i--) push_byte(mask_key[8*i +: 8]);
  endtask

  // Negative fill: random payload bytes.
  task automatic send_frame(input logic fin, input logic [2:0] rsv, input opcode_t op,
                            input logic mask, input logic [31:0] mask_key,
                            input longint unsigned len, input int fill);
    len_code_e enc;
    longint unsigned n;
    enc = (len <= 125) ? LEN_SHORT : (len <= 65535) ? LEN_EXT16 : LEN_EXT64;
    send_header(fin, rsv, op, mask, enc, len, mask_key);
    for (n = 0; n < len; n++)
      push_byte((fill < 0) ? byte_t'($urandom) : byte_t'(fill));
  endtask

  function automatic opcode_t pick_opcode();
    case ($urandom_range(5))
      0: return OP_CONT;
      1: return OP_TEXT;
      2: return OP_BIN;
      3: return OP_CLOSE;
      4: return OP_PING;
      default: return OP_PONG;
    endcase
  endfunction

  // Mostly short payloads; the 125/126 encoding boundary on purpose now and then.
  function automatic longint unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(12);
    if (r < 82) return $urandom_range(124, 13);
    if (r < 86) return 125;
    if (r < 90) return 126;
    return $urandom_range(160, 127);
  endfunction

  task automatic random_frames(input int unsigned budget);
    int unsigned stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at)
      send_frame($urandom_range(1), 3'($urandom_range(7)), pick_opcode(),
                 $urandom_range(99) < 70, $urandom, pick_len(), -1);
  endtask

  // One masked frame with a 16-bit extended length; the receiver holds off at its
  // start so the input side backs up, and part of it runs with no idling on either side.
  task automatic long_frame();
    longint unsigned frame_len;
    longint unsigned n;
    frame_len = 150 + $urandom_range(7);
    send_header(1'b1, 3'($urandom_range(7)), pick_opcode(), 1'b1, LEN_EXT16,
                frame_len, $urandom);
    stall_asked++;
    for (n = 0; n < frame_len; n++) begin
      if (n == 30) no_idle = 1'b1;
      if (n == 130) no_idle = 1'b0;
      push_byte(byte_t'($urandom));
    end
  endtask

  // Reset is applied once, so only one fault kind can be hit per run: pick it
  // at random, then feed noise that must be swallowed.
  task automatic closing_fault();
    int unsigned r;
    int i;
    logic [3:0] bad_op;
    logic [62:0] low_bits;
    case ($urandom_range(3))
      0: begin
        r = $urandom_range(9);
        bad_op = (r < 5) ? 4'(3 + r) : 4'(6 + r);
        push_byte({1'($urandom_range(1)), 3'($urandom_range(7)), bad_op});
      end
      1: send_header(1'b1, 3'd0, pick_opcode(), $urandom_range(1), LEN_EXT16,
                     $urandom_range(125), $urandom);
      2: begin
        r = $urandom_range(3);
        send_header(1'b0, 3'd0, pick_opcode(), $urandom_range(1), LEN_EXT64,
                    (r == 0) ? 64'd0 : (r == 1) ? 64'd65535 : 64'($urandom_range(65535)),
                    $urandom);
      end
      default: begin
        low_bits = {$urandom, $urandom};
        send_header(1'b1, 3'd0, pick_opcode(), $urandom_range(1), LEN_EXT64,
                    {1'b1, low_bits}, $urandom);
      end
    endcase
    for (i = 0; i < 24; i++) push_byte(byte_t'($urandom));
  endtask

  initial begin
    sb = new();
    bytes_sent = 0;
    no_idle = 1'b0;
    stall_asked = 0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.byte_in <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every opcode, empty frames, key of all zeros and all ones,
    // key wrap, payload extremes, unmasked pass-through.
    send_frame(1'b1, 3'b000, OP_CLOSE, 1'b0, 32'h0, 0, -1);
    send_frame(1'b0, 3'b111, OP_PING, 1'b1, 32'h0, 0, -1);
    send_frame(1'b1, 3'b100, OP_PONG, 1'b1, 32'hFFFF_FFFF, 1, 8'hFF);
    send_frame(1'b0, 3'b001, OP_TEXT, 1'b0, 32'h0, 2, 8'h00);
    send_frame(1'b1, 3'b010, OP_BIN, 1'b1, 32'hA5C3_3C5A, 5, 8'hFF);
    send_frame(1'b0, 3'b000, OP_CONT, 1'b0, 32'h0, 1, 8'hFF);

    random_frames(200);
    long_frame();
    random_frames(100);
    closing_fault();
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
